// File: src/set_assoc_lru_cache_sim_unit_defines.svh
// Assertion macros for the LRU cache simulator unit.
// Used by the checker module; needs nothing else.
`ifndef SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cache unit check failed");

// Next-cycle implication, disabled while reset is asserted
`define SALC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cache unit check failed");

`endif

// File: src/salc_pkg.sv
// Shared types and codes for the set-associative LRU cache simulator unit.
// No dependencies.
package salc_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned CntW     = 2;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_e;

  // Access outcome codes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [CntW-1:0]  access_count;
  } req_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic [TotalW-1:0] total_hits;
    logic [TotalW-1:0] total_misses;
    logic [TotalW-1:0] total_evictions;
  } rsp_t;

  // Saturating add of a small increment
  function automatic logic [TotalW-1:0] sat_add(input logic [TotalW-1:0] a,
                                                input logic [1:0] b);
    logic [TotalW:0] s;
    s = {1'b0, a} + {{(TotalW-1){1'b0}}, b};
    return s[TotalW] ? {TotalW{1'b1}} : s[TotalW-1:0];
  endfunction

endpackage

// File: src/set_assoc_lru_cache_sim_unit.sv
// Set-associative, tag-only cache model with LRU replacement: it classifies each address as a
// hit, a miss or a miss with eviction and reports saturating running totals. For each access
// the set's row is read from the tag memory and the state memory (valid bits and recency
// ranks) in the accept cycle; the lookup state then compares the enabled ways, picks the
// victim and, once the result register is free or being taken, writes the rows back and loads
// the result register; no new access is accepted before that. After reset a clearing pass
// writes the state memory one set per cycle, covering all 2^MAX_SET_BITS sets, before the first
// access is accepted; configuration writes are taken at any time. Depends on salc_pkg.
module set_assoc_lru_cache_sim_unit #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  salc_pkg::req_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output salc_pkg::rsp_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [salc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [salc_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned SetIdxW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned RankW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WayW    = RankW;

  typedef logic [MAX_WAYS-1:0][salc_pkg::AddrW-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][RankW-1:0]           rank_row_t;
  typedef struct packed {
    logic [MAX_WAYS-1:0] valid;
    rank_row_t           rank;
  } meta_row_t;

  // Configuration registers
  logic [2:0] set_bits_q;
  logic [4:0] offset_bits_q;
  logic [3:0] ways_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= 3'd0;
      offset_bits_q <= 5'd0;
      ways_q        <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        salc_pkg::REG_SET_BITS:    set_bits_q    <= cfg_data_i[2:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        salc_pkg::REG_WAYS:        ways_q        <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  salc_pkg::state_e state_q, state_d;
  logic [SetIdxW-1:0] clr_cnt_q;
  logic clr_last, in_acc, lookup_done, meta_we, tag_we;

  assign clr_last = (clr_cnt_q == SetIdxW'(NumSets - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      salc_pkg::ST_CLEAR:  if (clr_last) state_d = salc_pkg::ST_IDLE;
      salc_pkg::ST_IDLE:   if (in_valid_i) state_d = salc_pkg::ST_LOOKUP;
      salc_pkg::ST_LOOKUP: if (!out_valid_o || out_ready_i) state_d = salc_pkg::ST_IDLE;
      default:             state_d = salc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    lookup_done = 1'b0;
    case (state_q)
      salc_pkg::ST_IDLE:   in_ready_o  = 1'b1;
      salc_pkg::ST_LOOKUP: lookup_done = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= salc_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == salc_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Address split: offset, then set index, tag is the rest
  logic [4:0]                 sbits_eff;
  logic [salc_pkg::AddrW-1:0] above, set_mask, set_full, in_tag;
  logic [SetIdxW-1:0]         in_set;
  logic [1:0]                 in_cnt;

  always_comb begin
    sbits_eff = ({2'b0, set_bits_q} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                        : {2'b0, set_bits_q};
    above    = in_data_i.address >> offset_bits_q;
    in_tag   = above >> sbits_eff;
    set_mask = ~({salc_pkg::AddrW{1'b1}} << sbits_eff);
    set_full = above & set_mask;
    in_set   = set_full[SetIdxW-1:0];
    case (in_data_i.access_count)
      2'd0:    in_cnt = 2'd1;
      2'd3:    in_cnt = 2'd2;
      default: in_cnt = in_data_i.access_count;
    endcase
  end

  // Access held for the lookup cycle
  logic [SetIdxW-1:0]         set_q;
  logic [salc_pkg::AddrW-1:0] tag_q;
  logic [1:0]                 cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= in_set;
      tag_q <= in_tag;
      cnt_q <= in_cnt;
    end
  end

  // Memories: one row per set
  tag_row_t  tag_mem [NumSets];
  meta_row_t meta_mem [NumSets];
  tag_row_t  tag_rd_q, tag_row_d;
  meta_row_t meta_rd_q, meta_row_d, meta_wr;
  logic [SetIdxW-1:0] meta_wr_set;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[set_q] <= tag_row_d;
    if (in_acc) tag_rd_q <= tag_mem[in_set];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wr_set] <= meta_wr;
    if (in_acc) meta_rd_q <= meta_mem[in_set];
  end

  // Reset row for the clearing pass: nothing valid, way w at rank w
  meta_row_t meta_init;
  always_comb begin
    meta_init.valid = '0;
    for (int w = 0; w < MAX_WAYS; w++) meta_init.rank[w] = RankW'(w);
  end

  // Lookup: parallel tag compare, victim choice, rank update
  logic [4:0]          ways_lim;
  logic [MAX_WAYS-1:0] way_en, hit_vec, is_lru;
  logic                hit;
  logic [WayW-1:0]     hit_way, lru_way, touch_way;
  logic [RankW-1:0]    old_rank;
  logic                evict;

  always_comb begin
    if (ways_q == 4'd0)                   ways_lim = 5'd1;
    else if ({1'b0, ways_q} > 5'(MAX_WAYS)) ways_lim = 5'(MAX_WAYS);
    else                                  ways_lim = {1'b0, ways_q};

    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w]  = (5'(w) < ways_lim);
      hit_vec[w] = way_en[w] && meta_rd_q.valid[w] && (tag_rd_q[w] == tag_q);
    end
    hit = |hit_vec;

    // Lowest matching way wins
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WayW'(w);
    end

    // Ranks are a permutation, so exactly one enabled way ranks below the others
    for (int w = 0; w < MAX_WAYS; w++) begin
      is_lru[w] = way_en[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v != w && way_en[v] && !(meta_rd_q.rank[w] < meta_rd_q.rank[v]))
          is_lru[w] = 1'b0;
      end
    end
    lru_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (is_lru[w]) lru_way = lru_way | WayW'(w);
    end

    touch_way = hit ? hit_way : lru_way;
    old_rank  = meta_rd_q.rank[touch_way];
    evict     = !hit && meta_rd_q.valid[lru_way];

    // Touched way to the top, ranks above it move down
    meta_row_d = meta_rd_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (meta_rd_q.rank[w] > old_rank) meta_row_d.rank[w] = meta_rd_q.rank[w] - 1'b1;
    end
    meta_row_d.rank[touch_way] = RankW'(MAX_WAYS - 1);
    if (!hit) meta_row_d.valid[lru_way] = 1'b1;

    tag_row_d          = tag_rd_q;
    tag_row_d[lru_way] = tag_q;
  end

  assign tag_we      = lookup_done && !hit;
  assign meta_we     = lookup_done || (state_q == salc_pkg::ST_CLEAR);
  assign meta_wr_set = (state_q == salc_pkg::ST_CLEAR) ? clr_cnt_q : set_q;
  assign meta_wr     = (state_q == salc_pkg::ST_CLEAR) ? meta_init : meta_row_d;

  // Running totals
  logic [salc_pkg::TotalW-1:0] hits_q, misses_q, evicts_q, hits_d, misses_d, evicts_d;

  always_comb begin
    if (hit) begin
      hits_d   = salc_pkg::sat_add(hits_q, cnt_q);
      misses_d = misses_q;
      evicts_d = evicts_q;
    end else begin
      hits_d   = salc_pkg::sat_add(hits_q, cnt_q - 2'd1);
      misses_d = salc_pkg::sat_add(misses_q, 2'd1);
      evicts_d = evict ? salc_pkg::sat_add(evicts_q, 2'd1) : evicts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (lookup_done) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  // Result register
  logic           out_valid_q;
  salc_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lookup_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_done) begin
      rsp_q.outcome         <= hit ? salc_pkg::OUT_HIT
                                   : (evict ? salc_pkg::OUT_EVICT : salc_pkg::OUT_MISS);
      rsp_q.total_hits      <= hits_d;
      rsp_q.total_misses    <= misses_d;
      rsp_q.total_evictions <= evicts_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

// File: src/salc_checker.sv
// Port-level checks for the LRU cache simulator unit, bound to the top level.
// Depends on salc_pkg and set_assoc_lru_cache_sim_unit_defines.svh.
`include "set_assoc_lru_cache_sim_unit_defines.svh"

module salc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input salc_pkg::rsp_t                out_data_o
);

  // A held result stays put until taken
  `SALC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_data_o))

  // One access at a time: no accept in the cycle after an accept
  `SALC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A new result only comes out of a lookup cycle
  `SALC_ASSERT_NOW(a_out_after_lookup, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

  // Every eviction is also a miss
  `SALC_ASSERT_NOW(a_evict_le_miss, clk_i, rst_ni, out_valid_o,
                   out_data_o.total_evictions <= out_data_o.total_misses)

endmodule

bind set_assoc_lru_cache_sim_unit salc_checker u_salc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
